[hw/rtl/crg_pkg.sv]
package crg_pkg;

  localparam int COORD_BITS = 12;
  localparam int COMP_W = 20;
  localparam int DIR_W = 16;
  localparam int DIR_FRAC = 14;
  localparam int NDC_W = COORD_BITS + 19;
  localparam int D_W = COORD_BITS + 41;
  localparam int NORM_W = 30;
  localparam int QUEUE_DEPTH = 8;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 60;
  localparam int INV_W = 17;

  localparam logic [CFG_IDX_W-1:0] CFG_RIGHT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_UP = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FORWARD = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_EYE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_NEAR = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_W = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_H = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE = 3'd7;

  localparam logic MODE_PERSP = 1'b0;
  localparam logic MODE_ORTHO = 1'b1;

  localparam logic [CFG_DATA_W-1:0] FORWARD_RESET = 60'hFFC00_00000_00000;
  localparam logic signed [COMP_W-1:0] NEAR_RESET = 20'sd102;
  localparam logic [INV_W-1:0] INV_RESET = 17'd65536;

  typedef struct packed {
    logic signed [COMP_W-1:0] z;
    logic signed [COMP_W-1:0] y;
    logic signed [COMP_W-1:0] x;
  } vec3_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
  } pixel_t;

  typedef struct packed {
    logic signed [COMP_W-1:0] origin_x;
    logic signed [COMP_W-1:0] origin_y;
    logic signed [COMP_W-1:0] origin_z;
    logic signed [DIR_W-1:0] dir_x;
    logic signed [DIR_W-1:0] dir_y;
    logic signed [DIR_W-1:0] dir_z;
  } ray_t;

  typedef struct packed {
    vec3_t right;
    vec3_t up;
    vec3_t forward;
    vec3_t eye;
    logic signed [COMP_W-1:0] near;
    logic [INV_W-1:0] inv_w;
    logic [INV_W-1:0] inv_h;
    logic mode;
  } cfg_t;

  typedef struct packed {
    logic mode;
    logic [2:0][D_W-1:0] d;
    logic [2:0][D_W-1:0] acc;
  } qent_t;

  function automatic logic signed [COMP_W-1:0] vget(vec3_t v, logic [1:0] i);
    case (i)
      2'd0: vget = v.x;
      2'd1: vget = v.y;
      default: vget = v.z;
    endcase
  endfunction

endpackage

[hw/rtl/crg_front.sv]
module crg_front (
  input logic clk,
  input logic rst,
  input logic accept,
  input crg_pkg::pixel_t pixel,
  input crg_pkg::cfg_t cfg,
  output logic push,
  output crg_pkg::qent_t push_data,
  output logic [1:0] inflight
);
  import crg_pkg::*;

  localparam int SC_W = COORD_BITS + 18;
  localparam int PROD_W = NDC_W + COMP_W;
  localparam int FN_W = 2 * COMP_W;
  localparam logic signed [NDC_W-1:0] NDC_ONE = NDC_W'(65536);

  logic v1, v2, v3;
  logic mode1, mode2, mode3;
  logic [SC_W-1:0] sx, sy;
  logic signed [NDC_W-1:0] ndx, ndy;
  logic signed [PROD_W-1:0] rp [3];
  logic signed [PROD_W-1:0] upp [3];
  logic signed [FN_W-1:0] fn [3];
  logic signed [D_W-1:0] d3 [3];
  logic signed [D_W-1:0] acc3 [3];

  always_comb begin
    sx = {{INV_W{1'b0}}, pixel.pixel_x, 1'b1} * {{(COORD_BITS + 1){1'b0}}, cfg.inv_w};
    sy = {{INV_W{1'b0}}, pixel.pixel_y, 1'b1} * {{(COORD_BITS + 1){1'b0}}, cfg.inv_h};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= accept;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ndx <= $signed({1'b0, sx}) - NDC_ONE;
      ndy <= NDC_ONE - $signed({1'b0, sy});
      mode1 <= cfg.mode;
    end
    mode2 <= mode1;
    mode3 <= mode2;
    for (int i = 0; i < 3; i++) begin
      rp[i] <= vget(cfg.right, 2'(i)) * ndx;
      upp[i] <= vget(cfg.up, 2'(i)) * ndy;
      fn[i] <= vget(cfg.forward, 2'(i)) * cfg.near;
      d3[i] <= (D_W'(vget(cfg.forward, 2'(i))) <<< 16) + D_W'(rp[i]) + D_W'(upp[i]);
      acc3[i] <= (D_W'(vget(cfg.eye, 2'(i))) <<< 16) + D_W'(rp[i]) + D_W'(upp[i])
                 + (D_W'(fn[i]) <<< 6);
    end
  end

  always_comb begin
    push = v3;
    push_data.mode = mode3;
    for (int i = 0; i < 3; i++) begin
      push_data.d[i] = d3[i];
      push_data.acc[i] = acc3[i];
    end
    inflight = {1'b0, v1} + {1'b0, v2} + {1'b0, v3};
  end

endmodule

[hw/rtl/crg_queue.sv]
module crg_queue (
  input logic clk,
  input logic rst,
  input logic push,
  input crg_pkg::qent_t push_data,
  input logic pop,
  output crg_pkg::qent_t head,
  output logic nonempty,
  output logic [$clog2(crg_pkg::QUEUE_DEPTH):0] count
);
  import crg_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = PTR_W + 1;

  qent_t mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  assign head = mem[rd_ptr];
  assign nonempty = (count != '0);

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push && !pop |-> count != CNT_W'(QUEUE_DEPTH))
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> count != '0)
    else $error("queue read while empty");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count out of range");
  a_ptr_count: assert property (@(posedge clk) disable iff (rst)
    PTR_W'(wr_ptr - rd_ptr) == count[PTR_W-1:0])
    else $error("queue pointers disagree with count");
`endif

endmodule

[hw/rtl/crg_back.sv]
module crg_back (
  input logic clk,
  input logic rst,
  input crg_pkg::cfg_t cfg,
  input logic q_valid,
  input crg_pkg::qent_t q_head,
  output logic pop,
  output logic ray_valid,
  input logic ray_stall,
  output crg_pkg::ray_t ray
);
  import crg_pkg::*;

  localparam int MAG_W = D_W;
  localparam int G = (MAG_W + 7) / 8;
  localparam int GW = $clog2(G);
  localparam int PAD_W = G * 8;
  localparam int PW = GW + 3;
  localparam int TOP = NORM_W - 1;
  localparam int SQ_W = 2 * NORM_W;
  localparam int S_W = SQ_W + 2;
  localparam int SQ_STEPS = S_W / 2;
  localparam int RT_W = SQ_STEPS;
  localparam int RM_W = RT_W + 2;
  localparam int QB = DIR_FRAC + 1;
  localparam int NUM_W = NORM_W + QB;
  localparam int PRD_W = DIR_W + COMP_W;
  localparam int FX_W = COMP_W + 4;
  localparam logic signed [D_W-1:0] ROUND16 = D_W'(32768);
  localparam logic signed [PRD_W-1:0] ROUND14 = PRD_W'(8192);
  localparam logic signed [FX_W-1:0] FX_MAX = FX_W'(16384);
  localparam logic signed [FX_W-1:0] FX_MIN = -FX_W'(16384);
  localparam logic [QB-1:0] Q_ONE = QB'(16384);

  typedef struct packed {
    logic mode;
    logic [2:0] neg;
    logic [2:0][COMP_W-1:0] org;
    logic [2:0][DIR_W-1:0] dir;
  } carry_t;

  function automatic logic signed [COMP_W-1:0] sat_d(logic signed [D_W-1:0] v);
    if (v > D_W'(524287)) begin
      sat_d = 20'sd524287;
    end else if (v < -D_W'(524288)) begin
      sat_d = -20'sd524288;
    end else begin
      sat_d = v[COMP_W-1:0];
    end
  endfunction

  function automatic logic signed [COMP_W-1:0] sat_p(logic signed [PRD_W-1:0] v);
    if (v > PRD_W'(524287)) begin
      sat_p = 20'sd524287;
    end else if (v < -PRD_W'(524288)) begin
      sat_p = -20'sd524288;
    end else begin
      sat_p = v[COMP_W-1:0];
    end
  endfunction

  logic adv;
  assign adv = !(ray_valid && ray_stall);
  assign pop = adv && q_valid;

  // Magnitudes, signs and the finished orthographic ray.
  logic v0;
  carry_t c0, c0_next;
  logic [MAG_W-1:0] mag0 [3];
  logic [MAG_W-1:0] mag0_next [3];

  always_comb begin
    logic signed [D_W-1:0] t;
    logic signed [FX_W-1:0] fx;
    c0_next.mode = q_head.mode;
    for (int i = 0; i < 3; i++) begin
      c0_next.neg[i] = q_head.d[i][D_W-1];
      mag0_next[i] = q_head.d[i][D_W-1] ? (~q_head.d[i] + D_W'(1)) : q_head.d[i];
      t = ($signed(q_head.acc[i]) + ROUND16) >>> 16;
      c0_next.org[i] = sat_d(t);
      fx = $signed({vget(cfg.forward, 2'(i)), 4'b0000});
      if (fx > FX_MAX) begin
        c0_next.dir[i] = DIR_W'(16384);
      end else if (fx < FX_MIN) begin
        c0_next.dir[i] = -DIR_W'(16384);
      end else begin
        c0_next.dir[i] = fx[DIR_W-1:0];
      end
    end
  end

  // Largest magnitude.
  logic v1;
  carry_t c1;
  logic [MAG_W-1:0] mag1 [3];
  logic [MAG_W-1:0] mx1, mx1_next;

  always_comb begin
    mx1_next = (mag0[0] > mag0[1]) ? mag0[0] : mag0[1];
    mx1_next = (mag0[2] > mx1_next) ? mag0[2] : mx1_next;
  end

  // Leading one, first within each byte, then across bytes.
  logic v2;
  carry_t c2;
  logic [MAG_W-1:0] mag2 [3];
  logic gnz2 [G];
  logic [2:0] gpos2 [G];
  logic gnz_next [G];
  logic [2:0] gpos_next [G];

  always_comb begin
    logic [PAD_W-1:0] padded;
    logic [7:0] grp;
    padded = PAD_W'(mx1);
    for (int g = 0; g < G; g++) begin
      grp = padded[g*8 +: 8];
      gnz_next[g] = |grp;
      gpos_next[g] = 3'd0;
      for (int b = 0; b < 8; b++) begin
        if (grp[b]) begin
          gpos_next[g] = 3'(b);
        end
      end
    end
  end

  logic v3;
  carry_t c3;
  logic [MAG_W-1:0] mag3 [3];
  logic [PW-1:0] pos3, pos3_next;
  logic zero3, zero3_next;

  always_comb begin
    pos3_next = '0;
    zero3_next = 1'b1;
    for (int g = 0; g < G; g++) begin
      if (gnz2[g]) begin
        pos3_next = {GW'(g), gpos2[g]};
        zero3_next = 1'b0;
      end
    end
  end

  // Shared shift that puts the largest magnitude at the top bit.
  logic v4;
  carry_t c4;
  logic [NORM_W-1:0] nm4 [3];
  logic [NORM_W-1:0] nm4_next [3];
  logic zero4;

  always_comb begin
    logic [MAG_W-1:0] sh;
    for (int i = 0; i < 3; i++) begin
      if (pos3 >= PW'(TOP)) begin
        sh = mag3[i] >> (pos3 - PW'(TOP));
      end else begin
        sh = mag3[i] << (PW'(TOP) - pos3);
      end
      nm4_next[i] = sh[NORM_W-1:0];
    end
  end

  logic v5;
  carry_t c5;
  logic [NORM_W-1:0] nm5 [3];
  logic [SQ_W-1:0] sq5 [3];
  logic zero5;

  // Square root, one result bit per stage.
  logic sv [SQ_STEPS+1];
  carry_t sc [SQ_STEPS+1];
  logic [NORM_W-1:0] snm [SQ_STEPS+1][3];
  logic szero [SQ_STEPS+1];
  logic [RM_W-1:0] srem [SQ_STEPS+1];
  logic [RT_W-1:0] sroot [SQ_STEPS+1];
  logic [S_W-1:0] srest [SQ_STEPS+1];

  // Division, one quotient bit per stage in three lanes.
  logic dv [QB+1];
  carry_t dc [QB+1];
  logic dzero [QB+1];
  logic [RT_W-1:0] dlen [QB+1];
  logic [NUM_W-1:0] drem [QB+1][3];
  logic [QB-1:0] dq [QB+1][3];

  logic vf;
  carry_t cf;
  logic signed [DIR_W-1:0] dirf [3];
  logic signed [DIR_W-1:0] dirf_next [3];

  logic vm;
  carry_t cm;
  logic signed [DIR_W-1:0] dirm [3];
  logic signed [PRD_W-1:0] prodm [3];

  always_comb begin
    logic [QB-1:0] qc;
    logic [DIR_W-1:0] dmag;
    for (int i = 0; i < 3; i++) begin
      qc = (dq[QB][i] > Q_ONE) ? Q_ONE : dq[QB][i];
      dmag = {1'b0, qc};
      if (dzero[QB]) begin
        dirf_next[i] = '0;
      end else if (dc[QB].neg[i]) begin
        dirf_next[i] = $signed(DIR_W'(0) - dmag);
      end else begin
        dirf_next[i] = $signed(dmag);
      end
    end
  end

  logic signed [COMP_W-1:0] org_next [3];

  always_comb begin
    logic signed [PRD_W-1:0] t;
    for (int i = 0; i < 3; i++) begin
      t = (PRD_W'(vget(cfg.eye, 2'(i))) + ((prodm[i] + ROUND14) >>> DIR_FRAC));
      org_next[i] = (cm.mode == MODE_ORTHO) ? $signed(cm.org[i]) : sat_p(t);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      sv[0] <= 1'b0;
      dv[0] <= 1'b0;
      vf <= 1'b0;
      vm <= 1'b0;
      ray_valid <= 1'b0;
    end else if (adv) begin
      v0 <= q_valid;
      v1 <= v0;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      sv[0] <= v5;
      dv[0] <= sv[SQ_STEPS];
      vf <= dv[QB];
      vm <= vf;
      ray_valid <= vm;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c0 <= c0_next;
      c1 <= c0;
      c2 <= c1;
      c3 <= c2;
      c4 <= c3;
      c5 <= c4;
      sc[0] <= c5;
      dc[0] <= sc[SQ_STEPS];
      cf <= dc[QB];
      cm <= cf;
      mx1 <= mx1_next;
      pos3 <= pos3_next;
      zero3 <= zero3_next;
      zero4 <= zero3;
      zero5 <= zero4;
      szero[0] <= zero5;
      srem[0] <= '0;
      sroot[0] <= '0;
      srest[0] <= S_W'(sq5[0]) + S_W'(sq5[1]) + S_W'(sq5[2]);
      dzero[0] <= szero[SQ_STEPS];
      dlen[0] <= sroot[SQ_STEPS];
      for (int g = 0; g < G; g++) begin
        gnz2[g] <= gnz_next[g];
        gpos2[g] <= gpos_next[g];
      end
      for (int i = 0; i < 3; i++) begin
        mag0[i] <= mag0_next[i];
        mag1[i] <= mag0[i];
        mag2[i] <= mag1[i];
        mag3[i] <= mag2[i];
        nm4[i] <= nm4_next[i];
        nm5[i] <= nm4[i];
        sq5[i] <= SQ_W'(nm4[i]) * SQ_W'(nm4[i]);
        snm[0][i] <= nm5[i];
        drem[0][i] <= (NUM_W'(snm[SQ_STEPS][i]) << DIR_FRAC)
                      + NUM_W'(sroot[SQ_STEPS] >> 1);
        dq[0][i] <= '0;
        dirf[i] <= dirf_next[i];
        dirm[i] <= dirf[i];
        prodm[i] <= dirf[i] * cfg.near;
      end
      ray.origin_x <= org_next[0];
      ray.origin_y <= org_next[1];
      ray.origin_z <= org_next[2];
      ray.dir_x <= (cm.mode == MODE_ORTHO) ? $signed(cm.dir[0]) : dirm[0];
      ray.dir_y <= (cm.mode == MODE_ORTHO) ? $signed(cm.dir[1]) : dirm[1];
      ray.dir_z <= (cm.mode == MODE_ORTHO) ? $signed(cm.dir[2]) : dirm[2];
    end
  end

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
    logic [RM_W+1:0] rem2, trial;
    logic fit;

    always_comb begin
      rem2 = {srem[k], srest[k][S_W-1:S_W-2]};
      trial = (RM_W + 2)'({sroot[k], 2'b01});
      fit = (rem2 >= trial);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        sv[k+1] <= 1'b0;
      end else if (adv) begin
        sv[k+1] <= sv[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sc[k+1] <= sc[k];
        szero[k+1] <= szero[k];
        srem[k+1] <= fit ? RM_W'(rem2 - trial) : RM_W'(rem2);
        sroot[k+1] <= {sroot[k][RT_W-2:0], fit};
        srest[k+1] <= srest[k] << 2;
        for (int i = 0; i < 3; i++) begin
          snm[k+1][i] <= snm[k][i];
        end
      end
    end
  end

  for (genvar j = 0; j < QB; j++) begin : g_div
    localparam int B = QB - 1 - j;
    logic [NUM_W-1:0] dvs;
    logic [2:0] fit;

    always_comb begin
      dvs = NUM_W'(dlen[j]) << B;
      for (int i = 0; i < 3; i++) begin
        fit[i] = (drem[j][i] >= dvs);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv[j+1] <= 1'b0;
      end else if (adv) begin
        dv[j+1] <= dv[j];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dc[j+1] <= dc[j];
        dzero[j+1] <= dzero[j];
        dlen[j+1] <= dlen[j];
        for (int i = 0; i < 3; i++) begin
          drem[j+1][i] <= fit[i] ? (drem[j][i] - dvs) : drem[j][i];
          dq[j+1][i] <= {dq[j][i][QB-2:0], fit[i]};
        end
      end
    end
  end

endmodule

[hw/rtl/camera_ray_generate_unit.sv]
// Channel  Direction  Handshake                Payload
// pixel    in         pixel_valid/pixel_stall  pixel_x, pixel_y
// ray      out        ray_valid/ray_stall      origin_x/y/z, dir_x/y/z
// cfg      in         cfg_write_en             cfg_index, cfg_data
//
// One ray per cycle sustained while ray_stall is low.
// Three front stages feed an eight-entry queue; the back pipeline has 57 stages,
// of which 31 form the square root and 15 the three-lane divider.
// Reset is synchronous; it empties the pipeline and queue and loads register defaults.
// A ray stall freezes the back pipeline; the front keeps going while the queue has room.
module camera_ray_generate_unit (
  input logic clk,
  input logic rst,
  input logic pixel_valid,
  output logic pixel_stall,
  input crg_pkg::pixel_t pixel,
  output logic ray_valid,
  input logic ray_stall,
  output crg_pkg::ray_t ray,
  input logic cfg_write_en,
  input logic [crg_pkg::CFG_IDX_W-1:0] cfg_index,
  input logic [crg_pkg::CFG_DATA_W-1:0] cfg_data
);
  import crg_pkg::*;

  localparam int CNT_W = $clog2(QUEUE_DEPTH) + 1;

  cfg_t cfg;
  logic accept;
  logic push, pop, nonempty;
  qent_t push_data, head;
  logic [1:0] inflight;
  logic [CNT_W-1:0] count;
  logic [CNT_W:0] credits;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.right <= '0;
      cfg.up <= '0;
      cfg.forward <= FORWARD_RESET;
      cfg.eye <= '0;
      cfg.near <= NEAR_RESET;
      cfg.inv_w <= INV_RESET;
      cfg.inv_h <= INV_RESET;
      cfg.mode <= MODE_PERSP;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        CFG_RIGHT: cfg.right <= cfg_data;
        CFG_UP: cfg.up <= cfg_data;
        CFG_FORWARD: cfg.forward <= cfg_data;
        CFG_EYE: cfg.eye <= cfg_data;
        CFG_NEAR: cfg.near <= cfg_data[COMP_W-1:0];
        CFG_INV_W: cfg.inv_w <= cfg_data[INV_W-1:0];
        CFG_INV_H: cfg.inv_h <= cfg_data[INV_W-1:0];
        CFG_MODE: cfg.mode <= cfg_data[0];
      endcase
    end
  end

  assign credits = {1'b0, count} + (CNT_W + 1)'(inflight);
  assign pixel_stall = (credits >= (CNT_W + 1)'(QUEUE_DEPTH));
  assign accept = pixel_valid && !pixel_stall;

  crg_front u_front (
    .clk(clk),
    .rst(rst),
    .accept(accept),
    .pixel(pixel),
    .cfg(cfg),
    .push(push),
    .push_data(push_data),
    .inflight(inflight)
  );

  crg_queue u_queue (
    .clk(clk),
    .rst(rst),
    .push(push),
    .push_data(push_data),
    .pop(pop),
    .head(head),
    .nonempty(nonempty),
    .count(count)
  );

  crg_back u_back (
    .clk(clk),
    .rst(rst),
    .cfg(cfg),
    .q_valid(nonempty),
    .q_head(head),
    .pop(pop),
    .ray_valid(ray_valid),
    .ray_stall(ray_stall),
    .ray(ray)
  );

endmodule

[sim/tb_top.sv]
module tb_top;
  import crg_pkg::*;

  localparam int LATENCY = 60;
  localparam int STALL_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic pixel_valid = 1'b0;
  logic pixel_stall;
  pixel_t pixel = '0;
  logic ray_valid;
  logic ray_stall = 1'b0;
  ray_t ray;
  logic cfg_write_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  cfg_t cam;
  pixel_t pending_pixels[$];
  ray_t rays_due[$];
  int errors = 0;
  int quiet_cycles = 0;
  bit calm = 1'b0;

  camera_ray_generate_unit dut (
    .clk(clk), .rst(rst),
    .pixel_valid(pixel_valid), .pixel_stall(pixel_stall), .pixel(pixel),
    .ray_valid(ray_valid), .ray_stall(ray_stall), .ray(ray),
    .cfg_write_en(cfg_write_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic longint vcomp(vec3_t v, int i);
    case (i)
      0: return longint'(v.x);
      1: return longint'(v.y);
      default: return longint'(v.z);
    endcase
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned s);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > s) b = b >> 2;
    while (b != 0) begin
      if (s >= r + b) begin
        s = s - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic longint round_up_shift(longint v, int sh);
    return (v + (longint'(1) <<< (sh - 1))) >>> sh;
  endfunction

  // Computes the ray the camera should emit for one pixel under the current setup.
  function automatic ray_t trace_ray(pixel_t p);
    longint ndx, ndy, nearv, f, acc;
    longint d[3], org[3], dir[3];
    longint unsigned m[3];
    longint unsigned mx, s, len, q;
    ray_t r;
    ndx = (2 * longint'(p.pixel_x) + 1) * longint'(cam.inv_w) - 65536;
    ndy = 65536 - (2 * longint'(p.pixel_y) + 1) * longint'(cam.inv_h);
    nearv = longint'(cam.near);
    mx = 0;
    s = 0;
    if (cam.mode == MODE_PERSP) begin
      for (int i = 0; i < 3; i++) begin
        d[i] = vcomp(cam.forward, i) * 65536 + vcomp(cam.right, i) * ndx
             + vcomp(cam.up, i) * ndy;
        m[i] = (d[i] < 0) ? longint'(-d[i]) : d[i];
        if (m[i] > mx) mx = m[i];
      end
      if (mx == 0) begin
        for (int i = 0; i < 3; i++) dir[i] = 0;
      end else begin
        while (mx >= (64'd1 << 30)) begin
          mx = mx >> 1;
          for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
        end
        while (mx < (64'd1 << 29)) begin
          mx = mx << 1;
          for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
        end
        for (int i = 0; i < 3; i++) s = s + m[i] * m[i];
        len = int_sqrt(s);
        for (int i = 0; i < 3; i++) begin
          q = (m[i] * 16384 + len / 2) / len;
          if (q > 16384) q = 16384;
          dir[i] = (d[i] < 0) ? -longint'(q) : longint'(q);
        end
      end
      for (int i = 0; i < 3; i++)
        org[i] = clamp(vcomp(cam.eye, i) + round_up_shift(dir[i] * nearv, 14),
                       -524288, 524287);
    end else begin
      for (int i = 0; i < 3; i++) begin
        f = vcomp(cam.forward, i);
        acc = vcomp(cam.eye, i) * 65536 + vcomp(cam.right, i) * ndx
            + vcomp(cam.up, i) * ndy + f * nearv * 64;
        org[i] = clamp(round_up_shift(acc, 16), -524288, 524287);
        dir[i] = clamp(f * 16, -16384, 16384);
      end
    end
    r.origin_x = COMP_W'(org[0]);
    r.origin_y = COMP_W'(org[1]);
    r.origin_z = COMP_W'(org[2]);
    r.dir_x = DIR_W'(dir[0]);
    r.dir_y = DIR_W'(dir[1]);
    r.dir_z = DIR_W'(dir[2]);
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      pixel_valid <= 1'b0;
    end else begin
      if (pixel_valid && !pixel_stall) rays_due.push_back(trace_ray(pixel));
      if (!pixel_valid || !pixel_stall) begin
        if (pending_pixels.size() != 0 && (calm || $urandom_range(99) >= 16)) begin
          pixel_valid <= 1'b1;
          pixel <= pending_pixels.pop_front();
        end else begin
          pixel_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    ray_t want;
    if (rst) begin
      ray_stall <= 1'b0;
    end else begin
      if (ray_valid && !ray_stall) begin
        if (rays_due.size() == 0) begin
          $error("unexpected ray %h", ray);
          errors++;
        end else begin
          want = rays_due.pop_front();
          if (ray.origin_x !== want.origin_x) begin
            $error("origin_x expected %0d got %0d", want.origin_x, ray.origin_x);
            errors++;
          end
          if (ray.origin_y !== want.origin_y) begin
            $error("origin_y expected %0d got %0d", want.origin_y, ray.origin_y);
            errors++;
          end
          if (ray.origin_z !== want.origin_z) begin
            $error("origin_z expected %0d got %0d", want.origin_z, ray.origin_z);
            errors++;
          end
          if (ray.dir_x !== want.dir_x) begin
            $error("dir_x expected %0d got %0d", want.dir_x, ray.dir_x);
            errors++;
          end
          if (ray.dir_y !== want.dir_y) begin
            $error("dir_y expected %0d got %0d", want.dir_y, ray.dir_y);
            errors++;
          end
          if (ray.dir_z !== want.dir_z) begin
            $error("dir_z expected %0d got %0d", want.dir_z, ray.dir_z);
            errors++;
          end
        end
      end
      ray_stall <= !calm && ($urandom_range(99) < 16);
    end
  end

  always @(posedge clk) begin
    if (rst || (pixel_valid && !pixel_stall) || (ray_valid && !ray_stall)) begin
      quiet_cycles <= 0;
    end else if (pending_pixels.size() != 0 || pixel_valid || rays_due.size() != 0) begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_write_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      CFG_RIGHT: cam.right = val;
      CFG_UP: cam.up = val;
      CFG_FORWARD: cam.forward = val;
      CFG_EYE: cam.eye = val;
      CFG_NEAR: cam.near = val[COMP_W-1:0];
      CFG_INV_W: cam.inv_w = val[INV_W-1:0];
      CFG_INV_H: cam.inv_h = val[INV_W-1:0];
      default: cam.mode = val[0];
    endcase
    @(posedge clk);
  endtask

  // A transfer that is still being driven is not yet seen in the queues, so check again.
  task automatic drain();
    forever begin
      while (pending_pixels.size() != 0 || pixel_valid || rays_due.size() != 0)
        @(posedge clk);
      repeat (LATENCY + 10) @(posedge clk);
      if (pending_pixels.size() == 0 && !pixel_valid && rays_due.size() == 0) break;
    end
  endtask

  function automatic vec3_t rand_vec(bit wide);
    vec3_t v;
    if (wide) begin
      v = CFG_DATA_W'({$urandom, $urandom});
    end else begin
      v.x = COMP_W'($signed($urandom_range(4096)) - 2048);
      v.y = COMP_W'($signed($urandom_range(4096)) - 2048);
      v.z = COMP_W'($signed($urandom_range(4096)) - 2048);
    end
    return v;
  endfunction

  task automatic set_camera(vec3_t r, vec3_t u, vec3_t f, vec3_t e,
                            logic signed [COMP_W-1:0] nr,
                            logic [INV_W-1:0] iw, logic [INV_W-1:0] ih, logic md);
    drain();
    write_reg(CFG_RIGHT, r);
    write_reg(CFG_UP, u);
    write_reg(CFG_FORWARD, f);
    write_reg(CFG_EYE, e);
    write_reg(CFG_NEAR, {{(CFG_DATA_W-COMP_W){nr[COMP_W-1]}}, nr});
    write_reg(CFG_INV_W, CFG_DATA_W'(iw));
    write_reg(CFG_INV_H, CFG_DATA_W'(ih));
    write_reg(CFG_MODE, CFG_DATA_W'(md));
    cfg_write_en <= 1'b0;
  endtask

  task automatic add_pixel(int x, int y);
    pixel_t p;
    p.pixel_x = COORD_BITS'(x);
    p.pixel_y = COORD_BITS'(y);
    pending_pixels.push_back(p);
  endtask

  initial begin
    int wd, ht, w_px, h_px;
    bit wide;
    cam.right = '0;
    cam.up = '0;
    cam.forward = FORWARD_RESET;
    cam.eye = '0;
    cam.near = NEAR_RESET;
    cam.inv_w = INV_RESET;
    cam.inv_h = INV_RESET;
    cam.mode = MODE_PERSP;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    add_pixel(0, 0);
    add_pixel(4095, 4095);
    add_pixel(0, 4095);
    add_pixel(4095, 0);
    set_camera(vec3_t'({20'sd0, 20'sd0, 20'sd512}), vec3_t'({20'sd0, 20'sd384, 20'sd0}),
               FORWARD_RESET, '0, 20'sd1024, 17'd16384, 17'd16384, MODE_PERSP);
    for (int i = 0; i < 4; i++) add_pixel(i, 3 - i);
    add_pixel(1, 2);
    // A forward vector of zero, with right and up also zero, leaves no direction at all for any pixel.
    set_camera('0, '0, '0, vec3_t'({20'sd7, -20'sd9, 20'sd1000}), -20'sd300,
               17'd65536, 17'd65536, MODE_PERSP);
    add_pixel(0, 0);
    add_pixel(4095, 0);
    // The largest vectors and near distances drive the origin into saturation.
    set_camera({3{20'h7FFFF}}, {3{20'h80000}}, {3{20'h7FFFF}}, {3{20'h7FFFF}},
               20'sh7FFFF, 17'h1FFFF, 17'h1FFFF, MODE_PERSP);
    add_pixel(4095, 0);
    add_pixel(0, 4095);
    set_camera({3{20'h80000}}, {3{20'h7FFFF}}, {3{20'h80000}}, {3{20'h80000}},
               20'sh80000, 17'd0, 17'h1FFFF, MODE_ORTHO);
    add_pixel(4095, 4095);
    add_pixel(0, 0);
    add_pixel(2048, 1);
    set_camera(vec3_t'({20'sd0, 20'sd0, 20'sd800}), vec3_t'({20'sd0, 20'sd600, 20'sd0}),
               vec3_t'({-20'sd1024, 20'sd0, 20'sd0}), vec3_t'({20'sd5, 20'sd6, 20'sd7}),
               20'sd2048, 17'd32768, 17'd21845, MODE_ORTHO);
    for (int i = 0; i < 3; i++) add_pixel(i, i);

    for (int ph = 0; ph < 12; ph++) begin
      wide = (ph % 4 == 3);
      calm = (ph == 5);
      wd = $urandom_range(4096, 1);
      ht = $urandom_range(4096, 1);
      set_camera(rand_vec(wide), rand_vec(wide), rand_vec(wide), rand_vec(1'b1),
                 COMP_W'(wide ? $urandom : $urandom_range(4096)),
                 INV_W'(wide ? $urandom : 65536 / wd),
                 INV_W'(wide ? $urandom : 65536 / ht), ph[0]);
      for (int k = 0; k < 60; k++) begin
        if (wide || $urandom_range(9) == 0) begin
          add_pixel($urandom_range(4095), $urandom_range(4095));
        end else begin
          w_px = $urandom_range(wd - 1);
          h_px = $urandom_range(ht - 1);
          add_pixel(w_px, h_px);
        end
      end
    end
    calm = 1'b0;

    drain();
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
